FILE: sv/lgsp_pkg.sv
// Shared types, widths and constants of the light-gun serial pad.
// Depends on nothing; every other file of the block imports it.
package lgsp_pkg;

  // Beam geometry. The beam position is kept wide enough for any field value.
  localparam int DOTS_PER_LINE = 1364;
  localparam int VCOUNT_W      = 9;
  localparam int HCOUNT_W      = 11;
  localparam int BEAM_W        = $clog2((2**VCOUNT_W - 1) * DOTS_PER_LINE + 2**HCOUNT_W);

  // Field widths.
  localparam int MODE_W  = 2;
  localparam int DELTA_W = 8;
  localparam int BTN_W   = 4;
  localparam int POS_W   = 10;
  localparam int CNT_W   = 6;
  localparam int CFG_IDX_W = 1;

  // Report and screen constants.
  localparam int REPORT_BITS     = 32;
  localparam int TARGET_X_OFFSET = 24;
  localparam int SCREEN_WIDTH    = 256;
  localparam int LINES_OVERSCAN  = 240;
  localparam int LINES_NORMAL    = 225;
  localparam int POS_MIN         = -16;
  localparam int POS_X_MAX       = 256 + 16;
  localparam int POS_Y_MAX       = 240 + 16;

  // Pointer positions after reset or after a write of the chained register.
  localparam int SOLO_X_FIRST   = SCREEN_WIDTH / 2;
  localparam int SOLO_X_SECOND  = -1;
  localparam int SOLO_Y_SECOND  = -1;
  localparam int PAIR_X_FIRST   = SCREEN_WIDTH / 2 - 16;
  localparam int PAIR_X_SECOND  = SCREEN_WIDTH / 2 + 16;
  localparam int START_Y        = 240 / 2;

  typedef enum logic [MODE_W-1:0] {
    MODE_LATCH  = 2'd0,
    MODE_READ   = 2'd1,
    MODE_RASTER = 2'd2
  } mode_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHAINED  = 1'd0,
    CFG_OVERSCAN = 1'd1
  } cfg_idx_t;

  typedef logic signed [POS_W-1:0] pos_t;

  // One request as held in the input register.
  typedef struct packed {
    mode_t                     mode;
    logic                      latch_level;
    logic [BEAM_W-1:0]         beam;
    logic signed [DELTA_W-1:0] dx_first;
    logic signed [DELTA_W-1:0] dy_first;
    logic signed [DELTA_W-1:0] dx_second;
    logic signed [DELTA_W-1:0] dy_second;
    logic [BTN_W-1:0]          buttons;
  } item_t;

  typedef struct packed {
    logic chained;
    logic overscan;
  } cfg_t;

  // Request to reload the pointer positions after a chained write.
  typedef struct packed {
    logic load;
    logic chained;
  } pos_init_t;

  // Status from the serial side to the result register and raster logic.
  typedef struct packed {
    logic data_bit;
    logic gun_cur;
    logic gun_after;
  } ser_out_t;

endpackage

FILE: sv/lgsp_chan_if.sv
// Channel interfaces of the light-gun serial pad: input, result and configuration.
// Depends on lgsp_pkg for the field widths.
interface lgsp_in_if import lgsp_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [MODE_W-1:0]         mode;
  logic                      latch_level;
  logic [VCOUNT_W-1:0]       vcount;
  logic [HCOUNT_W-1:0]       hcount;
  logic signed [DELTA_W-1:0] dx_first;
  logic signed [DELTA_W-1:0] dy_first;
  logic signed [DELTA_W-1:0] dx_second;
  logic signed [DELTA_W-1:0] dy_second;
  logic [BTN_W-1:0]          buttons;

  modport source (output valid, mode, latch_level, vcount, hcount, dx_first, dy_first,
                  dx_second, dy_second, buttons, input ready);
  modport sink   (input valid, mode, latch_level, vcount, hcount, dx_first, dy_first,
                  dx_second, dy_second, buttons, output ready);
endinterface

interface lgsp_out_if;
  logic valid;
  logic ready;
  logic data_bit;
  logic strobe_pulse;
  logic active_gun;

  modport source (output valid, data_bit, strobe_pulse, active_gun, input ready);
  modport sink   (input valid, data_bit, strobe_pulse, active_gun, output ready);
endinterface

interface lgsp_cfg_if import lgsp_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic                 data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/lgsp_serial.sv
// Serial side of the pad: latch tracking, report bit counter, button sampling, active gun.
// Depends on lgsp_pkg.
module lgsp_serial import lgsp_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     fire,
  input  item_t    item,
  input  logic     chained,
  output ser_out_t status
);

  logic             latch_r, latch_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             gun_r, gun_nxt;
  logic [BTN_W-1:0] btn_r, btn_nxt;
  logic [BTN_W-1:0] btn_sample;
  logic             data_bit;

  function automatic logic report_bit(input logic [CNT_W-2:0] n, input logic [BTN_W-1:0] b,
                                      input logic gun);
    logic r;
    r = 1'b0;
    if (n >= 5'd12 && n <= 5'd14) r = 1'b1;
    else if (n >= 5'd16 && n <= 5'd23) r = n[0];
    else if (n == 5'd24) r = b[0];
    else if (n == 5'd25) r = b[2];
    else if (n == 5'd26) r = b[1];
    else if (n == 5'd27) r = b[3];
    else if (n == 5'd28) r = gun;
    return r;
  endfunction

  always_comb begin
    latch_nxt  = latch_r;
    cnt_nxt    = cnt_r;
    gun_nxt    = gun_r;
    btn_nxt    = btn_r;
    btn_sample = btn_r;
    data_bit   = 1'b0;
    if (fire) begin
      unique case (item.mode)
        MODE_LATCH: begin
          if (item.latch_level != latch_r) begin
            latch_nxt = item.latch_level;
            cnt_nxt   = '0;
            if (!item.latch_level) gun_nxt = ~gun_r;
          end
        end
        MODE_READ: begin
          if (cnt_r >= CNT_W'(REPORT_BITS)) begin
            data_bit = 1'b1;
          end else begin
            // Buttons are captured on the first bit; gun two only when it is there.
            if (cnt_r == '0) begin
              btn_sample = chained ? item.buttons : {btn_r[3:2], item.buttons[1:0]};
            end
            btn_nxt  = btn_sample;
            data_bit = report_bit(cnt_r[CNT_W-2:0], btn_sample, gun_r);
            cnt_nxt  = cnt_r + CNT_W'(1);
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_r <= 1'b0;
      cnt_r   <= '0;
      gun_r   <= 1'b0;
      btn_r   <= '0;
    end else begin
      latch_r <= latch_nxt;
      cnt_r   <= cnt_nxt;
      gun_r   <= gun_nxt;
      btn_r   <= btn_nxt;
    end
  end

  assign status.data_bit  = data_bit;
  assign status.gun_cur   = gun_r;
  assign status.gun_after = gun_nxt;

  a_cnt_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(REPORT_BITS))
    else $error("report bit counter ran past the end of the report");

  a_latch_clears_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    fire && item.mode == MODE_LATCH && item.latch_level != latch_r |=> cnt_r == '0)
    else $error("latch edge did not restart the report");

endmodule

FILE: sv/lgsp_raster.sv
// Raster side of the pad: pointer positions, strobe detection and frame-wrap movement.
// Depends on lgsp_pkg.
module lgsp_raster import lgsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  item_t     item,
  input  cfg_t      cfg,
  input  pos_init_t pos_init,
  input  logic      gun_cur,
  output logic      strobe
);

  pos_t              x1_r, y1_r, x2_r, y2_r;
  pos_t              x1_nxt, y1_nxt, x2_nxt, y2_nxt;
  logic [BEAM_W-1:0] prev_r, prev_nxt;
  pos_t              x_sel, y_sel, lines;
  logic              onscreen, wrap, tick;
  logic [BEAM_W-1:0] target;

  function automatic pos_t clamp_pos(input pos_t v, input pos_t hi);
    pos_t r;
    r = v;
    if (v < pos_t'(POS_MIN)) r = pos_t'(POS_MIN);
    else if (v > hi) r = hi;
    return r;
  endfunction

  always_comb begin
    tick  = fire && item.mode == MODE_RASTER;
    x_sel = gun_cur ? x2_r : x1_r;
    y_sel = gun_cur ? y2_r : y1_r;
    lines = cfg.overscan ? pos_t'(LINES_OVERSCAN) : pos_t'(LINES_NORMAL);
    onscreen = !(x_sel < 0 || y_sel < 0 || x_sel >= pos_t'(SCREEN_WIDTH) || y_sel >= lines);
    target = BEAM_W'(y_sel[7:0]) * BEAM_W'(DOTS_PER_LINE)
           + ((BEAM_W'(x_sel[7:0]) + BEAM_W'(TARGET_X_OFFSET)) << 2);
    strobe = tick && onscreen && item.beam >= target && prev_r < target;
    wrap   = item.beam < prev_r;

    x1_nxt   = x1_r;
    y1_nxt   = y1_r;
    x2_nxt   = x2_r;
    y2_nxt   = y2_r;
    prev_nxt = prev_r;
    if (pos_init.load) begin
      x1_nxt = pos_init.chained ? pos_t'(PAIR_X_FIRST) : pos_t'(SOLO_X_FIRST);
      y1_nxt = pos_t'(START_Y);
      x2_nxt = pos_init.chained ? pos_t'(PAIR_X_SECOND) : pos_t'(SOLO_X_SECOND);
      y2_nxt = pos_init.chained ? pos_t'(START_Y) : pos_t'(SOLO_Y_SECOND);
    end else if (tick) begin
      prev_nxt = item.beam;
      if (wrap) begin
        x1_nxt = clamp_pos(x1_r + pos_t'(item.dx_first), pos_t'(POS_X_MAX));
        y1_nxt = clamp_pos(y1_r + pos_t'(item.dy_first), pos_t'(POS_Y_MAX));
        if (cfg.chained) begin
          x2_nxt = clamp_pos(x2_r + pos_t'(item.dx_second), pos_t'(POS_X_MAX));
          y2_nxt = clamp_pos(y2_r + pos_t'(item.dy_second), pos_t'(POS_Y_MAX));
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x1_r   <= pos_t'(SOLO_X_FIRST);
      y1_r   <= pos_t'(START_Y);
      x2_r   <= pos_t'(SOLO_X_SECOND);
      y2_r   <= pos_t'(SOLO_Y_SECOND);
      prev_r <= '0;
    end else begin
      x1_r   <= x1_nxt;
      y1_r   <= y1_nxt;
      x2_r   <= x2_nxt;
      y2_r   <= y2_nxt;
      prev_r <= prev_nxt;
    end
  end

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    x1_r >= pos_t'(POS_MIN) && x1_r <= pos_t'(POS_X_MAX) &&
    y1_r >= pos_t'(POS_MIN) && y1_r <= pos_t'(POS_Y_MAX) &&
    x2_r >= pos_t'(POS_MIN) && x2_r <= pos_t'(POS_X_MAX) &&
    y2_r >= pos_t'(POS_MIN) && y2_r <= pos_t'(POS_Y_MAX))
    else $error("pointer position left its clamp range");

endmodule

FILE: sv/light_gun_serial_pad_unit.sv
// Top level of the light-gun serial pad: input register, serial and raster logic, result register.
// Depends on lgsp_pkg, lgsp_chan_if, lgsp_serial and lgsp_raster.
//
// The unit answers every request (latch write, data read or raster tick) with exactly one
// result, one request per clock cycle sustained while the consumer takes every result. The
// result is offered from the output register once the request has left the input register.
// A request is first captured in an input register,
// together with its beam position (line times dots per line plus dot), whose multiplier sits
// in front of that register. While it is held there, the serial logic and the raster logic
// work on it against the current state; when it moves on, the result is loaded into the
// output register while the state is updated; the raster path there is one constant
// multiplication for the target plus two compares. A new request is taken whenever the input
// register is empty or is moving on in the same cycle, so one further request is taken while
// a finished result waits for the consumer; after that the input stalls until the result is
// taken. Configuration writes are always accepted and take
// effect at once; writing the chained register also reloads both pointer positions. They are
// meant to be issued only while no request is in flight. There is no clearing pass after
// reset: the unit is ready as soon as reset is released.
module light_gun_serial_pad_unit import lgsp_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  lgsp_in_if.sink     in_ch,
  lgsp_out_if.source  out_ch,
  lgsp_cfg_if.sink    cfg_ch
);

  // Input register stage.
  logic     s1_valid_r, s1_valid_nxt;
  item_t    s1_item_r;
  item_t    in_item;
  logic     in_fire;
  logic     adv;

  // Result register stage.
  logic     out_valid_r, out_valid_nxt;
  logic     out_data_r, out_strobe_r, out_gun_r;

  // Configuration.
  logic      chained_r, overscan_r;
  logic      cfg_fire;
  cfg_t      cfg;
  pos_init_t pos_init;

  ser_out_t  ser_status;
  logic      strobe;

  // A held request moves on when the result register is free or being emptied.
  assign adv      = s1_valid_r && (!out_valid_r || out_ch.ready);
  assign in_ch.ready = !s1_valid_r || adv;
  assign in_fire  = in_ch.valid && in_ch.ready;

  always_comb begin
    in_item.mode        = mode_t'(in_ch.mode);
    in_item.latch_level = in_ch.latch_level;
    in_item.beam        = BEAM_W'(in_ch.vcount) * BEAM_W'(DOTS_PER_LINE)
                        + BEAM_W'(in_ch.hcount);
    in_item.dx_first    = in_ch.dx_first;
    in_item.dy_first    = in_ch.dy_first;
    in_item.dx_second   = in_ch.dx_second;
    in_item.dy_second   = in_ch.dy_second;
    in_item.buttons     = in_ch.buttons;
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) s1_valid_nxt = 1'b1;
    else if (adv) s1_valid_nxt = 1'b0;

    out_valid_nxt = out_valid_r;
    if (adv) out_valid_nxt = 1'b1;
    else if (out_ch.ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s1_item_r <= in_item;
    if (adv) begin
      out_data_r   <= ser_status.data_bit;
      out_strobe_r <= strobe;
      out_gun_r    <= ser_status.gun_after;
    end
  end

  // Configuration registers.
  assign cfg_ch.ready = 1'b1;
  assign cfg_fire     = cfg_ch.valid && cfg_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chained_r  <= 1'b0;
      overscan_r <= 1'b0;
    end else if (cfg_fire) begin
      unique case (cfg_idx_t'(cfg_ch.index))
        CFG_CHAINED:  chained_r  <= cfg_ch.data;
        CFG_OVERSCAN: overscan_r <= cfg_ch.data;
      endcase
    end
  end

  assign cfg.chained      = chained_r;
  assign cfg.overscan     = overscan_r;
  assign pos_init.load    = cfg_fire && cfg_idx_t'(cfg_ch.index) == CFG_CHAINED;
  assign pos_init.chained = cfg_ch.data;

  lgsp_serial u_serial (
    .clk     (clk),
    .rst_n   (rst_n),
    .fire    (adv),
    .item    (s1_item_r),
    .chained (chained_r),
    .status  (ser_status)
  );

  lgsp_raster u_raster (
    .clk      (clk),
    .rst_n    (rst_n),
    .fire     (adv),
    .item     (s1_item_r),
    .cfg      (cfg),
    .pos_init (pos_init),
    .gun_cur  (ser_status.gun_cur),
    .strobe   (strobe)
  );

  assign out_ch.valid        = out_valid_r;
  assign out_ch.data_bit     = out_data_r;
  assign out_ch.strobe_pulse = out_strobe_r;
  assign out_ch.active_gun   = out_gun_r;

  a_adv_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> out_valid_r)
    else $error("a processed request produced no result");

  a_strobe_only_raster: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item_r.mode != MODE_RASTER |=> !out_strobe_r)
    else $error("strobe raised for a request that is not a raster tick");

  a_data_only_read: assert property (@(posedge clk) disable iff (!rst_n)
    adv && s1_item_r.mode != MODE_READ |=> !out_data_r)
    else $error("data bit raised for a request that is not a data read");

endmodule
